[src/drmfb_pkg.sv]
// Shared types and constants of the mono framebuffer dither-and-rotate block.
// Depends on nothing; every module of the block imports it.
package drmfb_pkg;

    // Image geometry of the panel.
    localparam int LONG_SIDE     = 800;
    localparam int SHORT_SIDE    = 480;
    localparam int BYTES_PER_ROW = 100;

    localparam int MAX_SIDE   = (LONG_SIDE > SHORT_SIDE) ? LONG_SIDE : SHORT_SIDE;
    // Counters, fill level and line buffer address; one more than the longest row.
    localparam int DIM_W      = $clog2(MAX_SIDE + 1);
    localparam int LINE_DEPTH = MAX_SIDE + 1;
    localparam int BPR_W      = $clog2(BYTES_PER_ROW + 1);

    // Diffused error and per-column error entries stay within -128..127.
    localparam int ERR_W  = 8;
    localparam int GRAY_W = 8;
    localparam int ADDR_W = 16;

    typedef logic [DIM_W-1:0]         t_dim;
    typedef logic signed [ERR_W-1:0]  t_err;
    typedef logic [GRAY_W-1:0]        t_gray;

    typedef enum logic [1:0] {
        CFG_TRUE_COLOR = 2'd0,
        CFG_PORTRAIT   = 2'd1,
        CFG_TOP_DOWN   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic true_color;
        logic portrait;
        logic top_down;
    } t_cfg;

    typedef struct packed {
        logic en;
        t_dim addr;
        t_err data;
    } t_line_wr;

    typedef struct packed {
        logic [ADDR_W-1:0] byte_address;
        logic [2:0]        bit_index;
        logic              white;
        logic              image_done;
    } t_pix_res;

endpackage

[src/drmfb_gray.sv]
// Gray source for the pixel stage: 256-entry palette gray table and RGB luma.
// Depends on drmfb_pkg.
module drmfb_gray (
    input  logic                i_clk,
    input  logic                i_load,
    input  logic                i_take,
    input  logic                i_true_color,
    input  logic [7:0]          i_palette_index,
    input  logic [7:0]          i_red,
    input  logic [7:0]          i_green,
    input  logic [7:0]          i_blue,
    output drmfb_pkg::t_gray    o_gray
);
    import drmfb_pkg::*;

    t_gray       r_gray_mem [256];
    t_gray       r_tab;
    t_gray       r_luma;
    t_gray       luma_in;
    logic [15:0] luma_sum;

    // (77R + 150G + 29B) >> 8; the weights sum to 256 so 16 bits never overflow
    assign luma_sum = 16'(i_red) * 16'd77 + 16'(i_green) * 16'd150 + 16'(i_blue) * 16'd29;
    assign luma_in  = luma_sum[15:8];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_gray_mem[i_palette_index] <= luma_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_tab  <= r_gray_mem[i_palette_index];
            r_luma <= luma_in;
        end
    end

    assign o_gray = i_true_color ? r_luma : r_tab;

endmodule

[src/drmfb_line.sv]
// Error line buffer: one write port, one registered read port.
// Depends on drmfb_pkg.
module drmfb_line (
    input  logic                 i_clk,
    input  drmfb_pkg::t_line_wr  i_wr,
    input  drmfb_pkg::t_dim      i_rd_addr,
    output drmfb_pkg::t_err      o_rd_data
);
    import drmfb_pkg::*;

    t_err r_mem [LINE_DEPTH];
    t_err r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/drmfb_diffuse.sv]
// Pixel stage: position counters, error diffusion, threshold and panel address.
// Depends on drmfb_pkg; drives the error line buffer.
module drmfb_diffuse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  drmfb_pkg::t_cfg      i_cfg,
    input  logic                 i_fire,
    input  drmfb_pkg::t_gray     i_gray,
    input  drmfb_pkg::t_err      i_rd_data,
    output drmfb_pkg::t_dim      o_rd_addr,
    output drmfb_pkg::t_line_wr  o_wr,
    output drmfb_pkg::t_pix_res  o_res
);
    import drmfb_pkg::*;

    localparam int PROD_W = DIM_W + BPR_W;

    // Line buffer entries 0..r_fill-1 hold the finished next-row errors of the
    // previous row; the two entries after them sit in r_tail0/r_tail1, and
    // everything beyond reads as zero. r_acc_a/r_acc_b collect the next-row
    // error for the current column and the one after it; r_e7 is the 7/16
    // share that the previous pixel hands to this one.
    t_dim r_col, r_row, r_fill;
    t_err r_tail0, r_tail1, r_acc_a, r_acc_b, r_e7;
    t_dim n_col, n_row, n_fill;
    t_err n_tail0, n_tail1, n_acc_a, n_acc_b, n_e7;

    // state after the out-of-range fixups
    t_dim e_col, e_row, e_fill;
    t_err e_tail0, e_tail1, e_acc_a, e_acc_b, e_e7;

    t_dim               width, height, img_row, phy_x, phy_y;
    logic               last_col, done;
    logic [DIM_W:0]     k_idx, fill_x;
    t_err               err_in, err, e1, e3, e5, e7;
    logic signed [ERR_W:0] prev;
    logic signed [9:0]  gsum;
    t_gray              clamped;
    logic               white;
    logic signed [11:0] x1, m3, m5, m7, s3, s5, s7;
    logic [PROD_W-1:0]  addr_full;

    assign width  = i_cfg.portrait ? DIM_W'(SHORT_SIDE) : DIM_W'(LONG_SIDE);
    assign height = i_cfg.portrait ? DIM_W'(LONG_SIDE) : DIM_W'(SHORT_SIDE);

    always_comb begin
        // column past the row end (width shrank): close the row first
        if (r_col >= width) begin
            e_col   = '0;
            e_row   = r_row + 1'b1;
            e_fill  = r_col;
            e_tail0 = r_acc_a;
            e_tail1 = r_acc_b;
            e_acc_a = '0;
            e_acc_b = '0;
            e_e7    = '0;
        end else begin
            e_col   = r_col;
            e_row   = r_row;
            e_fill  = r_fill;
            e_tail0 = r_tail0;
            e_tail1 = r_tail1;
            e_acc_a = r_acc_a;
            e_acc_b = r_acc_b;
            e_e7    = r_e7;
        end
        // row past the image end (height shrank): start a fresh image
        if (e_row >= height) begin
            e_col   = '0;
            e_row   = '0;
            e_fill  = '0;
            e_tail0 = '0;
            e_tail1 = '0;
            e_acc_a = '0;
            e_acc_b = '0;
            e_e7    = '0;
        end
    end

    // error carried to this pixel from the row above
    always_comb begin
        k_idx  = {1'b0, e_col} + 1'b1;
        fill_x = {1'b0, e_fill};
        if (k_idx < fill_x) begin
            err_in = i_rd_data;
        end else if (k_idx == fill_x) begin
            err_in = e_tail0;
        end else if (k_idx == fill_x + 1'b1) begin
            err_in = e_tail1;
        end else begin
            err_in = '0;
        end
    end

    assign prev = {err_in[ERR_W-1], err_in} + {e_e7[ERR_W-1], e_e7};
    assign gsum = $signed({2'b00, i_gray}) + {{(10-ERR_W-1){prev[ERR_W]}}, prev};

    always_comb begin
        if (gsum[9]) begin
            clamped = '0;
        end else if (gsum[8]) begin
            clamped = '1;
        end else begin
            clamped = gsum[7:0];
        end
    end

    assign white = clamped[7];
    // white: clamped - 255, which is clamped + 1 in 8-bit two's complement
    assign err   = $signed(clamped + {7'd0, white});

    assign x1 = {{(12-ERR_W){err[ERR_W-1]}}, err};
    assign m3 = (x1 <<< 1) + x1;
    assign m5 = (x1 <<< 2) + x1;
    assign m7 = (x1 <<< 3) - x1;
    assign s3 = m3 >>> 4;
    assign s5 = m5 >>> 4;
    assign s7 = m7 >>> 4;
    assign e3 = s3[ERR_W-1:0];
    assign e5 = s5[ERR_W-1:0];
    assign e7 = s7[ERR_W-1:0];
    assign e1 = err >>> 4;

    assign last_col = (e_col == width - 1'b1);
    assign done     = last_col && (e_row == height - 1'b1);

    // next-row error for this column is complete once this pixel adds its 3/16
    assign o_wr.en   = i_fire;
    assign o_wr.addr = e_col;
    assign o_wr.data = e_acc_a + e3;

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_fill  = r_fill;
        n_tail0 = r_tail0;
        n_tail1 = r_tail1;
        n_acc_a = r_acc_a;
        n_acc_b = r_acc_b;
        n_e7    = r_e7;
        if (i_fire) begin
            if (done) begin
                n_col   = '0;
                n_row   = '0;
                n_fill  = '0;
                n_tail0 = '0;
                n_tail1 = '0;
                n_acc_a = '0;
                n_acc_b = '0;
                n_e7    = '0;
            end else if (last_col) begin
                n_col   = '0;
                n_row   = e_row + 1'b1;
                n_fill  = width;
                n_tail0 = e_acc_b + e5;
                n_tail1 = e1;
                n_acc_a = '0;
                n_acc_b = '0;
                n_e7    = '0;
            end else begin
                n_col   = e_col + 1'b1;
                n_row   = e_row;
                n_fill  = e_fill;
                n_tail0 = e_tail0;
                n_tail1 = e_tail1;
                n_acc_a = e_acc_b + e5;
                n_acc_b = e1;
                n_e7    = e7;
            end
        end
    end

    // prefetch the entry the next pixel needs
    assign o_rd_addr = ((n_col >= width) ? '0 : n_col) + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_fill  <= '0;
            r_tail0 <= '0;
            r_tail1 <= '0;
            r_acc_a <= '0;
            r_acc_b <= '0;
            r_e7    <= '0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_fill  <= n_fill;
            r_tail0 <= n_tail0;
            r_tail1 <= n_tail1;
            r_acc_a <= n_acc_a;
            r_acc_b <= n_acc_b;
            r_e7    <= n_e7;
        end
    end

    // panel position
    assign img_row   = i_cfg.top_down ? e_row : (height - 1'b1 - e_row);
    assign phy_x     = i_cfg.portrait ? img_row : e_col;
    assign phy_y     = i_cfg.portrait ? (DIM_W'(SHORT_SIDE - 1) - e_col) : img_row;
    assign addr_full = PROD_W'(phy_y) * PROD_W'(BYTES_PER_ROW) + PROD_W'(phy_x >> 3);

    assign o_res.byte_address = ADDR_W'(addr_full);
    assign o_res.bit_index    = ~phy_x[2:0];
    assign o_res.white        = white;
    assign o_res.image_done   = done;

endmodule

[src/dither_rotate_to_mono_framebuffer.sv]
// Top level of the mono framebuffer dither-and-rotate block.
// Depends on drmfb_pkg, drmfb_gray, drmfb_line and drmfb_diffuse.
//
// Takes palette loads and pixels, one transfer per cycle while the input is not
// stalled, and returns for each pixel the framebuffer byte address, bit index and
// black/white decision with Floyd-Steinberg error diffusion. A pixel is
// registered on input (palette table read and RGB luma), then processed against
// the error line once the output register can take it, and lands in the output
// register; one pixel per cycle is sustained while the output is taken.
// The rate is set by the single pixel stage, which updates the column state
// and the error line for every pixel it processes. A palette load is written
// into the gray table on its input transfer and produces no result. A
// configuration write stalls the input for that cycle. The error lines start
// clear after reset with no clearing pass; memories are a 256 x 8 gray table
// and a (longest side + 1) x 8 error line buffer.
module dither_rotate_to_mono_framebuffer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic        i_cfg_wdata,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [7:0]  i_palette_index,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_byte_address,
    output logic [2:0]  o_bit_index,
    output logic        o_white,
    output logic        o_image_done
);
    import drmfb_pkg::*;

    t_cfg     r_cfg;
    logic     r_s1_valid;
    logic     r_out_valid;
    t_pix_res r_out;

    logic     in_xfer;
    logic     s1_fire;
    t_gray    s1_gray;
    t_err     rd_data;
    t_dim     rd_addr;
    t_line_wr line_wr;
    t_pix_res s1_res;

    // The pixel stage moves on whenever the output register is empty or is
    // being emptied; the input waits when it cannot move or on a config write.
    assign s1_fire    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = i_cfg_we || (r_s1_valid && !s1_fire);
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TRUE_COLOR: r_cfg.true_color <= i_cfg_wdata;
                CFG_PORTRAIT:   r_cfg.portrait   <= i_cfg_wdata;
                CFG_TOP_DOWN:   r_cfg.top_down   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer && i_req_type) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    drmfb_gray u_gray (
        .i_clk           (i_clk),
        .i_load          (in_xfer && !i_req_type),
        .i_take          (in_xfer && i_req_type),
        .i_true_color    (r_cfg.true_color),
        .i_palette_index (i_palette_index),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .o_gray          (s1_gray)
    );

    drmfb_line u_line (
        .i_clk     (i_clk),
        .i_wr      (line_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    drmfb_diffuse u_diffuse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_fire    (s1_fire),
        .i_gray    (s1_gray),
        .i_rd_data (rd_data),
        .o_rd_addr (rd_addr),
        .o_wr      (line_wr),
        .o_res     (s1_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out <= s1_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_byte_address = r_out.byte_address;
    assign o_bit_index    = r_out.bit_index;
    assign o_white        = r_out.white;
    assign o_image_done   = r_out.image_done;

endmodule

[tb/dither_rotate_to_mono_framebuffer_tb.sv]
// Testbench for the dither-and-rotate block: a scoreboard class predicts every pixel result.
// Tasks drive palette loads, pixels and register writes; the result side is stalled at random.
// Depends on drmfb_pkg and dither_rotate_to_mono_framebuffer.
module dither_rotate_to_mono_framebuffer_tb;
    import drmfb_pkg::*;

    // request type codes on i_req_type
    localparam bit REQ_PALETTE = 1'b0;
    localparam bit REQ_PIXEL   = 1'b1;

    // error line: one guard entry on each side of the longest row
    localparam int LINE_LEN = LONG_SIDE + 2;

    // ------------------------------------------------------------------
    // Scoreboard: own copy of the gray table, error lines and position.
    // take_transfer runs the dither step for each accepted input transfer;
    // check_pixel compares a result transfer with the oldest prediction.
    // ------------------------------------------------------------------
    class dither_scoreboard;
        bit           true_color;
        bit           portrait;
        bit           top_down;
        byte unsigned gray_lut [256];
        int           err_cur [LINE_LEN];
        int           err_nxt [LINE_LEN];
        int           col_count;
        int           row_count;
        int           images_done;
        int           pixels;
        int           loads;
        int           checked;
        t_pix_res     expected_pixels [$];

        function void set_reg(t_cfg_idx idx, bit val);
            case (idx)
                CFG_TRUE_COLOR: true_color = val;
                CFG_PORTRAIT:   portrait   = val;
                CFG_TOP_DOWN:   top_down   = val;
                default: ;
            endcase
        endfunction

        function int luma(int r, int g, int b);
            return (r * 77 + g * 150 + b * 29) >> 8;
        endfunction

        function void clear_lines();
            foreach (err_cur[k]) begin
                err_cur[k] = 0;
                err_nxt[k] = 0;
            end
        endfunction

        // next row's errors become current, next row starts clean
        function void advance_row();
            foreach (err_cur[k]) begin
                err_cur[k] = err_nxt[k];
                err_nxt[k] = 0;
            end
            col_count = 0;
            row_count++;
        endfunction

        function void take_transfer(bit req, logic [7:0] idx, logic [7:0] r,
                                    logic [7:0] g, logic [7:0] b);
            int       w;
            int       h;
            int       col;
            int       gray;
            int       err;
            int       img_row;
            int       phy_x;
            int       phy_y;
            int       addr;
            bit       white;
            bit       done;
            t_pix_res res;
            if (req == REQ_PALETTE) begin
                gray_lut[idx] = 8'(luma(r, g, b));
                loads++;
                return;
            end
            pixels++;
            w = portrait ? SHORT_SIDE : LONG_SIDE;
            h = portrait ? LONG_SIDE : SHORT_SIDE;
            // a register change can leave the position outside the new shape
            if (col_count >= w)
                advance_row();
            if (row_count >= h) begin
                clear_lines();
                col_count = 0;
                row_count = 0;
            end
            col = col_count;

            gray = true_color ? luma(r, g, b) : int'(gray_lut[idx]);
            gray += err_cur[col + 1];
            if (gray < 0)
                gray = 0;
            if (gray > 255)
                gray = 255;
            white = (gray >= 128);
            err   = gray - (white ? 255 : 0);

            img_row = top_down ? row_count : (h - 1 - row_count);
            if (portrait) begin
                phy_x = img_row;
                phy_y = SHORT_SIDE - 1 - col;
            end else begin
                phy_x = col;
                phy_y = img_row;
            end
            addr = phy_y * BYTES_PER_ROW + phy_x / 8;

            // floor shares of the error, 7/16 right and 3/5/1 below
            err_cur[col + 2] += (err * 7) >>> 4;
            err_nxt[col]     += (err * 3) >>> 4;
            err_nxt[col + 1] += (err * 5) >>> 4;
            err_nxt[col + 2] += err >>> 4;

            done = (row_count == h - 1) && (col == w - 1);

            res.byte_address = addr[ADDR_W-1:0];
            res.bit_index    = 3'(7 - (phy_x % 8));
            res.white        = white;
            res.image_done   = done;
            expected_pixels.push_back(res);

            if (done) begin
                clear_lines();
                col_count = 0;
                row_count = 0;
                images_done++;
            end else if (col == w - 1) begin
                advance_row();
            end else begin
                col_count = col + 1;
            end
        endfunction

        // empty string on a match, else one line naming every wrong field
        function string check_pixel(logic [15:0] addr, logic [2:0] bit_idx,
                                    logic white, logic done);
            t_pix_res want;
            string    why;
            if (expected_pixels.size() == 0)
                return $sformatf("unexpected result addr %0d bit %0d white %0b done %0b",
                                 addr, bit_idx, white, done);
            want = expected_pixels.pop_front();
            why  = "";
            if (addr !== want.byte_address)
                why = {why, $sformatf(" byte_address %0d/%0d", addr, want.byte_address)};
            if (bit_idx !== want.bit_index)
                why = {why, $sformatf(" bit_index %0d/%0d", bit_idx, want.bit_index)};
            if (white !== want.white)
                why = {why, $sformatf(" white %0b/%0b", white, want.white)};
            if (done !== want.image_done)
                why = {why, $sformatf(" image_done %0b/%0b", done, want.image_done)};
            if (why != "")
                why = $sformatf("pixel %0d (got/want):%s", checked, why);
            checked++;
            return why;
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT signals; every input known from time zero
    // ------------------------------------------------------------------
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic [1:0]  i_cfg_index     = CFG_TRUE_COLOR;
    logic        i_cfg_wdata     = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_stall;
    logic        i_req_type      = REQ_PALETTE;
    logic [7:0]  i_palette_index = 8'd0;
    logic [7:0]  i_red           = 8'd0;
    logic [7:0]  i_green         = 8'd0;
    logic [7:0]  i_blue          = 8'd0;
    logic        o_out_valid;
    logic        i_out_stall     = 1'b0;
    logic [15:0] o_byte_address;
    logic [2:0]  o_bit_index;
    logic        o_white;
    logic        o_image_done;

    dither_rotate_to_mono_framebuffer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_palette_index (i_palette_index),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_byte_address  (o_byte_address),
        .o_bit_index     (o_bit_index),
        .o_white         (o_white),
        .o_image_done    (o_image_done)
    );

    dither_scoreboard sb;
    int               n_errors;
    int               tx_idle_pct;      // chance of a gap before an input transfer
    int               rx_idle_pct;      // chance of a stall per cycle on the result side
    logic [7:0]       loaded_q [$];     // palette entries written so far
    bit               loaded_map [256];
    bit [7:0]         cfg_seen;         // register combinations used, {tc,po,td}
    string            mon_why;

    // one line per mismatch
    task automatic report_mismatch(input string why);
        n_errors++;
        $display("MISMATCH @%0t: %s", $time, why);
    endtask

    // 10-unit clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: random stall, changed on the falling edge
    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(99) < rx_idle_pct);

    // result monitor: a transfer is valid high and stall low at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            mon_why = sb.check_pixel(o_byte_address, o_bit_index, o_white, o_image_done);
            if (mon_why != "")
                report_mismatch(mon_why);
        end
    end

    function automatic logic [7:0] pick_color();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return 8'd0;
        if (roll < 20)
            return 8'd255;
        return 8'($urandom);
    endfunction

    // Drive one input transfer, starting and ending at a falling edge.
    // Valid is left high; the next call or wait_idle decides what follows.
    task automatic send_transfer(input bit req, input logic [7:0] idx,
                                 input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b);
        int gap;
        if ($urandom_range(99) < tx_idle_pct) begin
            gap = $urandom_range(4, 1);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_req_type      <= req;
        i_palette_index <= idx;
        i_red           <= r;
        i_green         <= g;
        i_blue          <= b;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.take_transfer(req, idx, r, g, b);
        if (req == REQ_PALETTE && !loaded_map[idx]) begin
            loaded_map[idx] = 1'b1;
            loaded_q.push_back(idx);
        end
        @(negedge i_clk);
    endtask

    // Random item: a palette load now and then, otherwise a pixel. Palette-mode
    // pixels only use entries that were written.
    task automatic send_random(input int load_pct);
        logic [7:0] idx;
        if ($urandom_range(99) < load_pct) begin
            send_transfer(REQ_PALETTE, 8'($urandom), pick_color(), pick_color(), pick_color());
        end else begin
            idx = sb.true_color ? 8'($urandom)
                                : loaded_q[$urandom_range(loaded_q.size() - 1)];
            send_transfer(REQ_PIXEL, idx, pick_color(), pick_color(), pick_color());
        end
    endtask

    // Drop valid, wait for every predicted result, then idle until
    // the two-stage pipe is empty.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.expected_pixels.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // three back-to-back register writes; write enable drops once at the end
    task automatic set_config(input bit tc, input bit po, input bit td);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TRUE_COLOR;
        i_cfg_wdata <= tc;
        @(negedge i_clk);
        i_cfg_index <= CFG_PORTRAIT;
        i_cfg_wdata <= po;
        @(negedge i_clk);
        i_cfg_index <= CFG_TOP_DOWN;
        i_cfg_wdata <= td;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(CFG_TRUE_COLOR, tc);
        sb.set_reg(CFG_PORTRAIT, po);
        sb.set_reg(CFG_TOP_DOWN, td);
        cfg_seen[{tc, po, td}] = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int sent;
        int len;
        int phase_no;
        bit [2:0] cfg;
        sb = new();
        tx_idle_pct = 0;
        rx_idle_pct = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: palette extremes, palette-mode pixels, a load mid-image,
        // then true-color extremes in rotated portrait, top-down.
        set_config(1'b0, 1'b0, 1'b0);
        send_transfer(REQ_PALETTE, 8'd0,   8'd0,   8'd0,   8'd0);
        send_transfer(REQ_PALETTE, 8'd255, 8'd255, 8'd255, 8'd255);
        send_transfer(REQ_PALETTE, 8'd128, 8'd255, 8'd0,   8'd0);
        send_transfer(REQ_PALETTE, 8'd1,   8'd0,   8'd255, 8'd0);
        send_transfer(REQ_PALETTE, 8'd2,   8'd0,   8'd0,   8'd255);
        send_transfer(REQ_PALETTE, 8'd127, 8'd128, 8'd128, 8'd128);
        send_transfer(REQ_PIXEL,   8'd255, 8'd0,   8'd0,   8'd0);
        send_transfer(REQ_PIXEL,   8'd0,   8'd255, 8'd255, 8'd255);
        send_transfer(REQ_PIXEL,   8'd127, 8'd0,   8'd0,   8'd0);   // right at threshold
        send_transfer(REQ_PIXEL,   8'd127, 8'd0,   8'd0,   8'd0);
        send_transfer(REQ_PIXEL,   8'd1,   8'd0,   8'd0,   8'd0);
        send_transfer(REQ_PIXEL,   8'd2,   8'd0,   8'd0,   8'd0);
        send_transfer(REQ_PIXEL,   8'd128, 8'd0,   8'd0,   8'd0);
        send_transfer(REQ_PALETTE, 8'd3,   8'h55,  8'hAA,  8'h55);  // load inside an image
        send_transfer(REQ_PIXEL,   8'd3,   8'd0,   8'd0,   8'd0);
        wait_idle();
        set_config(1'b1, 1'b1, 1'b1);
        send_transfer(REQ_PIXEL,   8'd0,   8'd255, 8'd255, 8'd255);
        send_transfer(REQ_PIXEL,   8'd255, 8'd0,   8'd0,   8'd0);
        send_transfer(REQ_PIXEL,   8'd0,   8'd255, 8'd0,   8'd0);
        send_transfer(REQ_PIXEL,   8'd0,   8'd0,   8'd255, 8'd0);
        send_transfer(REQ_PIXEL,   8'd0,   8'd0,   8'd0,   8'd255);
        send_transfer(REQ_PIXEL,   8'd0,   8'd128, 8'd128, 8'd128);
        send_transfer(REQ_PIXEL,   8'd0,   8'd127, 8'd127, 8'd127);

        // Random: three idling profiles, each split into runs with a fresh
        // register setting. Landscape-to-portrait switches mid-row land
        // columns out of range on their own.
        phase_no = 0;
        for (int p = 0; p < 3; p++) begin
            tx_idle_pct = (p == 0) ? 32 : (p == 1) ? 63 : 0;
            rx_idle_pct = (p == 0) ? 63 : (p == 1) ? 32 : 0;
            sent = 0;
            while (sent < 480) begin
                wait_idle();
                if (phase_no == 0)
                    cfg = 3'b111;
                else if (phase_no == 1)
                    cfg = 3'b000;
                else
                    cfg = 3'($urandom);
                set_config(cfg[2], cfg[1], cfg[0]);
                len = $urandom_range(250, 40);
                if (len > 480 - sent)
                    len = 480 - sent;
                repeat (len)
                    send_random(15);
                sent += len;
                phase_no++;
            end
        end

        // Full-speed sweep for the column special case: landscape past
        // column 480, then portrait, which leaves the column out of range.
        wait_idle();
        set_config(1'($urandom), 1'b0, 1'($urandom));
        while (sb.col_count < 500)
            send_random(2);
        wait_idle();
        set_config(sb.true_color, 1'b1, sb.top_down);
        repeat (16)
            send_random(2);

        wait_idle();
        repeat (8) @(negedge i_clk);

        $display("run: %0d pixels, %0d palette loads, %0d results checked, %0d image(s) ended",
                 sb.pixels, sb.loads, sb.checked, sb.images_done);
        $display("run: %0d of 8 register combinations, %0d random phases, %0d mismatches",
                 $countones(cfg_seen), phase_no, n_errors);
        if (n_errors == 0 && sb.expected_pixels.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (about two thousand items
    // under the heaviest idling).
    initial begin
        #30_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[filelist.f]
src/drmfb_pkg.sv
src/drmfb_gray.sv
src/drmfb_line.sv
src/drmfb_diffuse.sv
src/dither_rotate_to_mono_framebuffer.sv
tb/dither_rotate_to_mono_framebuffer_tb.sv
